@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; they compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/rhaf_pkg.sv @@
// Types, register map, constants and saturation helpers of the aero force block.
package rhaf_pkg;

    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int NUM_LIFT_WORDS = 5;
    localparam int NUM_TERMS      = 10;
    localparam int COEFS_PER_WORD = 4;
    localparam int COEF_W         = 16;
    localparam int MONO_W         = 48;
    localparam int TERM_W         = 61;
    localparam int LIFT_W         = 19;

    localparam logic [CFG_IDX_W-1:0] REG_LIFT0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT4  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAINS  = 3'd7;

    localparam logic [CFG_DATA_W-1:0] AXLE_RST  = 64'h0003_0000_0001_999A;
    localparam logic [CFG_DATA_W-1:0] GAINS_RST = 64'h0000_9CCD_0000_9CCD;

    localparam logic [LIFT_W-1:0]        LIFT_MAX = 19'd327680;
    localparam logic signed [MONO_W-1:0] MONO_ONE = 48'sd65536;
    localparam logic signed [63:0]       TERM_LIM = 64'sd576460752303423488;

    localparam logic signed [127:0] S48_MAX = 128'sd140737488355327;
    localparam logic signed [127:0] S48_MIN = -128'sd140737488355328;
    localparam logic signed [63:0]  S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0]  S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] heave;
        logic signed [31:0] pitch;
        logic signed [31:0] speed_long;
        logic signed [31:0] speed_lat;
    } rhaf_in_t;

    typedef struct packed {
        logic signed [47:0] force_long;
        logic signed [47:0] force_lat;
        logic signed [47:0] force_vert;
        logic signed [47:0] pitch_torque;
        logic signed [31:0] height_front;
        logic signed [31:0] height_rear;
    } rhaf_out_t;

    function automatic logic signed [47:0] sat48(input logic signed [127:0] v);
        logic signed [47:0] r;
        if (v > S48_MAX) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < S48_MIN) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/rhaf_lift.sv @@
// One cubic lift surface: term products, saturation, adder tree, scaling and clamp.
module rhaf_lift #(
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [rhaf_pkg::COEF_W-1:0]    coef [rhaf_pkg::NUM_TERMS],
    input  logic signed [rhaf_pkg::MONO_W-1:0]    mono [rhaf_pkg::NUM_TERMS],
    output logic        [rhaf_pkg::LIFT_W-1:0]    clift
);
    import rhaf_pkg::*;

    localparam int NUM_PAIRS = NUM_TERMS / 2;

    logic signed [63:0]       prod_reg [NUM_TERMS];
    logic signed [63:0]       prod_next [NUM_TERMS];
    logic signed [TERM_W:0]   pair_reg [NUM_PAIRS];
    logic signed [TERM_W:0]   pair_next [NUM_PAIRS];
    logic signed [TERM_W-1:0] term_sat [NUM_TERMS];
    logic        [LIFT_W-1:0] clift_reg;
    logic        [LIFT_W-1:0] clift_next;
    logic signed [63:0]       total;
    logic signed [63:0]       scaled;

    always_comb begin
        for (int i = 0; i < NUM_TERMS; i++) begin
            prod_next[i] = 64'(coef[i]) * 64'(mono[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TERMS; i++) begin
            if (prod_reg[i] > TERM_LIM) begin
                term_sat[i] = TERM_W'(TERM_LIM);
            end else if (prod_reg[i] < -TERM_LIM) begin
                term_sat[i] = TERM_W'(-TERM_LIM);
            end else begin
                term_sat[i] = TERM_W'(prod_reg[i]);
            end
        end
        for (int j = 0; j < NUM_PAIRS; j++) begin
            pair_next[j] = (TERM_W+1)'(term_sat[2*j]) + (TERM_W+1)'(term_sat[2*j+1]);
        end
    end

    always_comb begin
        total = 64'(pair_reg[0]) + 64'(pair_reg[1]) + 64'(pair_reg[2])
              + 64'(pair_reg[3]) + 64'(pair_reg[4]);
        scaled = total >>> COEF_FRAC_BITS;
        if (scaled < 64'sd0) begin
            clift_next = '0;
        end else if (scaled > $signed(64'(LIFT_MAX))) begin
            clift_next = LIFT_MAX;
        end else begin
            clift_next = scaled[LIFT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            pair_reg  <= pair_next;
            clift_reg <= clift_next;
        end
    end

    assign clift = clift_reg;

endmodule

@@ hw/rtl/ride_height_aero_force.sv @@
// Top level of the ride-height dependent aerodynamic force pipeline.
// Takes one word per clock while the output is not stalled, with no dependence
// between words; each result passes through the 13-stage multiplier pipeline
// (heights, monomial chain, lift surfaces, dynamic pressure, torque products).
// The whole pipeline advances whenever the output register is empty or taken;
// s_ready is low only when m_valid is high and m_ready is low. Registers are
// written through cfg_we by the user while no word is in flight; not enforced.
`include "assert_macros.svh"

module ride_height_aero_force #(
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rhaf_pkg::rhaf_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rhaf_pkg::rhaf_out_t                 m_data,
    input  logic                                cfg_we,
    input  logic [rhaf_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [rhaf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rhaf_pkg::*;

    localparam int NUM_STAGES = 13;

    typedef struct packed {
        logic signed [47:0] fx;
        logic signed [47:0] fy;
        logic        [62:0] q;
        logic signed [31:0] hf;
        logic signed [31:0] hr;
    } side_t;

    // configuration
    logic [CFG_DATA_W-1:0] lift_word_reg [NUM_LIFT_WORDS];
    logic [CFG_DATA_W-1:0] axle_reg, static_reg, gains_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LIFT_WORDS; i++) begin
                lift_word_reg[i] <= '0;
            end
            axle_reg   <= AXLE_RST;
            static_reg <= '0;
            gains_reg  <= GAINS_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_LIFT0:  lift_word_reg[0] <= cfg_wdata;
                REG_LIFT1:  lift_word_reg[1] <= cfg_wdata;
                REG_LIFT2:  lift_word_reg[2] <= cfg_wdata;
                REG_LIFT3:  lift_word_reg[3] <= cfg_wdata;
                REG_LIFT4:  lift_word_reg[4] <= cfg_wdata;
                REG_AXLE:   axle_reg <= cfg_wdata;
                REG_STATIC: static_reg <= cfg_wdata;
                REG_GAINS:  gains_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic        [31:0] arm, gd, gl;
    logic signed [32:0] rarm;
    logic signed [31:0] sf, sr;

    assign arm  = axle_reg[31:0];
    assign rarm = $signed({1'b0, axle_reg[63:32]}) - $signed({1'b0, arm});
    assign sf   = $signed(static_reg[31:0]);
    assign sr   = $signed(static_reg[63:32]);
    assign gd   = gains_reg[31:0];
    assign gl   = gains_reg[63:32];

    logic signed [COEF_W-1:0] coef_front [NUM_TERMS];
    logic signed [COEF_W-1:0] coef_rear [NUM_TERMS];

    for (genvar g = 0; g < NUM_TERMS; g++) begin : g_coef
        assign coef_front[g] = $signed(
            lift_word_reg[g / COEFS_PER_WORD][COEF_W*(g % COEFS_PER_WORD) +: COEF_W]);
        assign coef_rear[g] = $signed(
            lift_word_reg[(g + NUM_TERMS) / COEFS_PER_WORD]
                         [COEF_W*((g + NUM_TERMS) % COEFS_PER_WORD) +: COEF_W]);
    end

    // pipeline control
    logic                  en;
    logic [NUM_STAGES:1]   v_reg;

    assign en      = !v_reg[NUM_STAGES] || m_ready;
    assign s_ready = en;
    assign m_valid = v_reg[NUM_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NUM_STAGES-1:1], s_valid};
        end
    end

    // stage 1: axle products, squared speeds
    logic signed [64:0] armpit1_reg, armpit1_next, rarmpit1_reg, rarmpit1_next;
    logic signed [31:0] heave1_reg;
    logic signed [63:0] vx_w, vy_w;
    logic        [63:0] vxsq1_reg, vxsq1_next, vysq1_reg, vysq1_next;
    logic               vxneg1_reg, vyneg1_reg;

    always_comb begin
        armpit1_next  = $signed({1'b0, arm}) * s_data.pitch;
        rarmpit1_next = rarm * s_data.pitch;
        vx_w          = 64'(s_data.speed_long);
        vy_w          = 64'(s_data.speed_lat);
        vxsq1_next    = vx_w * vx_w;
        vysq1_next    = vy_w * vy_w;
    end

    // stage 2: saturated heights, gain partial products
    logic signed [31:0] hf2_reg, hf2_next, hr2_reg, hr2_next;
    logic        [63:0] fxa2_reg, fxa2_next, fxb2_reg, fxb2_next;
    logic        [63:0] fya2_reg, fya2_next, fyb2_reg, fyb2_next;
    logic        [63:0] qa2_reg, qa2_next, qb2_reg, qb2_next;
    logic               vxneg2_reg, vyneg2_reg;

    always_comb begin
        hf2_next  = sat32(64'(heave1_reg) - 64'(armpit1_reg >>> 16) - 64'(sf));
        hr2_next  = sat32(64'(heave1_reg) + 64'(rarmpit1_reg >>> 16) - 64'(sr));
        fxa2_next = 64'(vxsq1_reg[63:32]) * 64'(gd);
        fxb2_next = 64'(vxsq1_reg[31:0]) * 64'(gd);
        fya2_next = 64'(vysq1_reg[63:32]) * 64'(gd);
        fyb2_next = 64'(vysq1_reg[31:0]) * 64'(gd);
        qa2_next  = 64'(vxsq1_reg[63:32]) * 64'(gl);
        qb2_next  = 64'(vxsq1_reg[31:0]) * 64'(gl);
    end

    // stage 3: recombined products, height squares and cross product
    logic        [95:0] tx3_reg, tx3_next, ty3_reg, ty3_next, qsum;
    logic        [62:0] q3_reg, q3_next;
    logic signed [63:0] pff3_reg, pff3_next, prr3_reg, prr3_next, pfr3_reg, pfr3_next;
    logic signed [31:0] hf3_reg, hr3_reg;
    logic               vxneg3_reg, vyneg3_reg;

    always_comb begin
        tx3_next  = (96'(fxa2_reg) << 32) + 96'(fxb2_reg);
        ty3_next  = (96'(fya2_reg) << 32) + 96'(fyb2_reg);
        qsum      = (96'(qa2_reg) << 32) + 96'(qb2_reg);
        q3_next   = qsum[94:32];
        pff3_next = 64'(hf2_reg) * 64'(hf2_reg);
        prr3_next = 64'(hr2_reg) * 64'(hr2_reg);
        pfr3_next = 64'(hf2_reg) * 64'(hr2_reg);
    end

    // stage 4: drag forces, second-order monomials
    side_t              side_reg [4:NUM_STAGES-1];
    side_t              side4_next;
    logic signed [47:0] m2_4_reg, m2_4_next, m5_4_reg, m5_4_next, m7_4_reg, m7_4_next;

    always_comb begin
        if (vxneg3_reg) begin
            side4_next.fx = sat48(128'($signed({1'b0, tx3_reg}) >>> 32));
        end else begin
            side4_next.fx = sat48(128'((-$signed({1'b0, tx3_reg})) >>> 32));
        end
        if (vyneg3_reg) begin
            side4_next.fy = sat48(128'($signed({1'b0, ty3_reg}) >>> 32));
        end else begin
            side4_next.fy = sat48(128'((-$signed({1'b0, ty3_reg})) >>> 32));
        end
        side4_next.q  = q3_reg;
        side4_next.hf = hf3_reg;
        side4_next.hr = hr3_reg;
        m2_4_next = sat48(128'(pff3_reg >>> 16));
        m5_4_next = sat48(128'(prr3_reg >>> 16));
        m7_4_next = sat48(128'(pfr3_reg >>> 16));
    end

    // stage 5: split partial products of the third-order monomials
    logic signed [47:0] xsel [4];
    logic signed [31:0] ysel [4];
    logic signed [63:0] ph5_reg [4];
    logic signed [63:0] ph5_next [4];
    logic signed [48:0] pl5_reg [4];
    logic signed [48:0] pl5_next [4];
    logic signed [47:0] m2_5_reg, m5_5_reg, m7_5_reg;

    always_comb begin
        xsel[0] = m2_4_reg;
        ysel[0] = side_reg[4].hf;
        xsel[1] = m5_4_reg;
        ysel[1] = side_reg[4].hr;
        xsel[2] = m2_4_reg;
        ysel[2] = side_reg[4].hr;
        xsel[3] = m5_4_reg;
        ysel[3] = side_reg[4].hf;
        for (int i = 0; i < 4; i++) begin
            ph5_next[i] = 64'($signed(xsel[i][47:16])) * 64'(ysel[i]);
            pl5_next[i] = 49'($signed({1'b0, xsel[i][15:0]})) * 49'(ysel[i]);
        end
    end

    // stage 6: monomial vector
    logic signed [MONO_W-1:0] mono6_reg [NUM_TERMS];
    logic signed [MONO_W-1:0] mono6_next [NUM_TERMS];
    logic signed [MONO_W-1:0] cubic [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            cubic[i] = sat48(128'(ph5_reg[i]) + 128'(pl5_reg[i] >>> 16));
        end
        mono6_next[0] = MONO_ONE;
        mono6_next[1] = 48'(side_reg[5].hf);
        mono6_next[2] = m2_5_reg;
        mono6_next[3] = cubic[0];
        mono6_next[4] = 48'(side_reg[5].hr);
        mono6_next[5] = m5_5_reg;
        mono6_next[6] = cubic[1];
        mono6_next[7] = m7_5_reg;
        mono6_next[8] = cubic[2];
        mono6_next[9] = cubic[3];
    end

    // stages 7 to 9: lift surfaces
    logic [LIFT_W-1:0] clf9, clr9;

    rhaf_lift #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lift_front (
        .aclk (aclk),
        .en   (en),
        .coef (coef_front),
        .mono (mono6_reg),
        .clift(clf9)
    );

    rhaf_lift #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lift_rear (
        .aclk (aclk),
        .en   (en),
        .coef (coef_rear),
        .mono (mono6_reg),
        .clift(clr9)
    );

    // stage 10: vertical and moment-arm products
    logic        [LIFT_W:0] csum;
    logic        [50:0]     fzh10_reg, fzh10_next, kf10_reg, kf10_next;
    logic        [51:0]     fzl10_reg, fzl10_next;
    logic signed [52:0]     kr10_reg, kr10_next;

    always_comb begin
        csum       = (LIFT_W+1)'(clf9) + (LIFT_W+1)'(clr9);
        fzh10_next = 51'(csum) * 51'(side_reg[9].q[62:32]);
        fzl10_next = 52'(csum) * 52'(side_reg[9].q[31:0]);
        kf10_next  = 51'(clf9) * 51'(arm);
        kr10_next  = 53'($signed({1'b0, clr9})) * 53'(rarm);
    end

    // stage 11: vertical product sum, torque arm
    logic        [83:0] p11_reg, p11_next;
    logic signed [53:0] k11_reg, k11_next;

    always_comb begin
        p11_next = (84'(fzh10_reg) << 32) + 84'(fzl10_reg);
        k11_next = $signed(54'(kf10_reg)) - 54'(kr10_reg);
    end

    // stage 12: vertical force, torque partial products
    logic signed [47:0] fz12_reg, fz12_next;
    logic        [30:0] qh;
    logic        [31:0] ql, kl;
    logic signed [21:0] kh;
    logic signed [53:0] thh12_reg, thh12_next;
    logic        [62:0] thl12_reg, thl12_next;
    logic signed [54:0] tlh12_reg, tlh12_next;
    logic        [63:0] tll12_reg, tll12_next;

    always_comb begin
        fz12_next  = sat48(128'((-$signed({1'b0, p11_reg})) >>> 16));
        qh         = side_reg[11].q[62:32];
        ql         = side_reg[11].q[31:0];
        kh         = $signed(k11_reg[53:32]);
        kl         = k11_reg[31:0];
        thh12_next = 54'($signed({1'b0, qh})) * 54'(kh);
        thl12_next = 63'(qh) * 63'(kl);
        tlh12_next = 55'($signed({1'b0, ql})) * 55'(kh);
        tll12_next = 64'(ql) * 64'(kl);
    end

    // stage 13: output register
    rhaf_out_t out_reg, out_next;

    always_comb begin
        out_next.force_long   = side_reg[12].fx;
        out_next.force_lat    = side_reg[12].fy;
        out_next.force_vert   = fz12_reg;
        out_next.pitch_torque = sat48((128'(thh12_reg) <<< 32)
                                      + 128'($signed({1'b0, thl12_reg}))
                                      + 128'(tlh12_reg)
                                      + 128'($signed({1'b0, tll12_reg[63:32]})));
        out_next.height_front = side_reg[12].hf;
        out_next.height_rear  = side_reg[12].hr;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            armpit1_reg  <= armpit1_next;
            rarmpit1_reg <= rarmpit1_next;
            heave1_reg   <= s_data.heave;
            vxsq1_reg    <= vxsq1_next;
            vysq1_reg    <= vysq1_next;
            vxneg1_reg   <= s_data.speed_long[31];
            vyneg1_reg   <= s_data.speed_lat[31];

            hf2_reg    <= hf2_next;
            hr2_reg    <= hr2_next;
            fxa2_reg   <= fxa2_next;
            fxb2_reg   <= fxb2_next;
            fya2_reg   <= fya2_next;
            fyb2_reg   <= fyb2_next;
            qa2_reg    <= qa2_next;
            qb2_reg    <= qb2_next;
            vxneg2_reg <= vxneg1_reg;
            vyneg2_reg <= vyneg1_reg;

            tx3_reg    <= tx3_next;
            ty3_reg    <= ty3_next;
            q3_reg     <= q3_next;
            pff3_reg   <= pff3_next;
            prr3_reg   <= prr3_next;
            pfr3_reg   <= pfr3_next;
            hf3_reg    <= hf2_reg;
            hr3_reg    <= hr2_reg;
            vxneg3_reg <= vxneg2_reg;
            vyneg3_reg <= vyneg2_reg;

            side_reg[4] <= side4_next;
            for (int k = 5; k < NUM_STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            m2_4_reg <= m2_4_next;
            m5_4_reg <= m5_4_next;
            m7_4_reg <= m7_4_next;

            ph5_reg  <= ph5_next;
            pl5_reg  <= pl5_next;
            m2_5_reg <= m2_4_reg;
            m5_5_reg <= m5_4_reg;
            m7_5_reg <= m7_4_reg;

            mono6_reg <= mono6_next;

            fzh10_reg <= fzh10_next;
            fzl10_reg <= fzl10_next;
            kf10_reg  <= kf10_next;
            kr10_reg  <= kr10_next;

            p11_reg <= p11_next;
            k11_reg <= k11_next;

            fz12_reg  <= fz12_next;
            thh12_reg <= thh12_next;
            thl12_reg <= thl12_next;
            tlh12_reg <= tlh12_next;
            tll12_reg <= tll12_next;

            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    `ASSERT_NEXT(a_stall_freezes_valids, aclk, aresetn, !s_ready, $stable(v_reg))
    `ASSERT_NEXT(a_valid_advances, aclk, aresetn, s_ready, v_reg[2] == $past(v_reg[1]))
    `ASSERT_SAME(a_lift_clamped, aclk, aresetn, v_reg[9], (clf9 <= LIFT_MAX) && (clr9 <= LIFT_MAX))
    `ASSERT_SAME(a_vert_not_up, aclk, aresetn, m_valid, m_data.force_vert[47] || (m_data.force_vert == '0))

endmodule
